>>> rtl/touch_sample_filter_and_press_tracker_top_assert.svh
// Assertion macros for the touch sample filter and press tracker.
// Included by the top level; the bodies are empty in synthesis builds.
`ifndef TOUCH_SAMPLE_FILTER_AND_PRESS_TRACKER_TOP_ASSERT_SVH
`define TOUCH_SAMPLE_FILTER_AND_PRESS_TRACKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TSF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("touch filter assertion failed");
`define TSF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("touch filter assertion failed");
`else
`define TSF_ASSERT(name, clk, rst_n, prop)
`define TSF_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/tsf_pkg.sv
// Shared constants, register codes and stage types of the touch sample filter.
// No dependencies; every other file of the block but the assertion header uses it.
`timescale 1ns / 1ps

package tsf_pkg;

  localparam int unsigned SAMPLES_PER_GROUP = 5;
  localparam int unsigned DROP_EACH_END     = 1;
  localparam int unsigned ADC_BITS          = 12;

  localparam int unsigned KEEP_CNT = SAMPLES_PER_GROUP - 2 * DROP_EACH_END;
  localparam int unsigned SLOT_W   = $clog2(SAMPLES_PER_GROUP);
  localparam int unsigned GRP_W    = 2;
  localparam int unsigned SUM_W    = ADC_BITS + $clog2(SAMPLES_PER_GROUP);
  localparam int unsigned MEANS    = 3;

  localparam logic [GRP_W-1:0] LAST_GRP = 2'd3;

  // Division of the kept sum by KEEP_CNT as a multiply by a rounded-up
  // reciprocal; with the extra log2 bits of shift the quotient is exact.
  localparam int unsigned DIV_SHIFT   = SUM_W + $clog2(KEEP_CNT);
  localparam int unsigned DIV_RECIP_W = DIV_SHIFT + 1;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
    DIV_RECIP_W'(((longint'(1) << DIV_SHIFT) + longint'(KEEP_CNT) - 1) / longint'(KEEP_CNT));
  localparam int unsigned DIV_PROD_W  = SUM_W + DIV_RECIP_W;

  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned GAIN_FRAC  = 16;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned WIN_W      = ADC_BITS;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned CAL_PROD_W = GAIN_W + ADC_BITS;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [GAIN_W-1:0] X_GAIN_RST   = 17'd4129;
  localparam logic [OFF_W-1:0]  X_OFFSET_RST = 16'hFFF4;
  localparam logic [GAIN_W-1:0] Y_GAIN_RST   = 17'd5866;
  localparam logic [OFF_W-1:0]  Y_OFFSET_RST = 16'hFFE0;
  localparam logic [WIN_W-1:0]  WINDOW_RST   = 12'd50;
  localparam logic [POS_W-1:0]  POS_IDLE     = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_GAIN,
    CFG_X_OFFSET,
    CFG_Y_GAIN,
    CFG_Y_OFFSET,
    CFG_AGREE_WINDOW
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] x_gain;
    logic [OFF_W-1:0]  x_offset;
    logic [GAIN_W-1:0] y_gain;
    logic [OFF_W-1:0]  y_offset;
    logic [WIN_W-1:0]  window;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic                pen_down;
    logic [ADC_BITS-1:0] sample;
    logic                raw_mode;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic             pen_down;
    logic             grp_end;
    logic [GRP_W-1:0] grp;
    logic             raw_mode;
    logic [SUM_W-1:0] kept_sum;
  } sum_beat_t;

  typedef struct packed {
    logic                valid;
    logic                pen_down;
    logic                grp_end;
    logic [GRP_W-1:0]    grp;
    logic                raw_mode;
    logic [ADC_BITS-1:0] mean;
  } mean_beat_t;

  typedef struct packed {
    logic                valid;
    logic                pen_down;
    logic                scan_end;
    logic                raw_mode;
    logic                ok;
    logic [ADC_BITS-1:0] ax;
    logic [ADC_BITS-1:0] ay;
  } pair_beat_t;

  typedef struct packed {
    logic             valid;
    logic             pen_down;
    logic             scan_end;
    logic             ok;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } calib_beat_t;

  typedef struct packed {
    logic             pressed;
    logic             caught;
    logic             reading_valid;
    logic [POS_W-1:0] x_position;
    logic [POS_W-1:0] y_position;
    logic [POS_W-1:0] first_x;
    logic [POS_W-1:0] first_y;
  } result_t;

endpackage

>>> rtl/tsf_in_if.sv
// Input channel of the touch sample filter: one ADC sample or pen-up event per beat.
// Depends on tsf_pkg for the sample width.
`timescale 1ns / 1ps

interface tsf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         pen_down;
  logic [tsf_pkg::ADC_BITS-1:0] sample;
  logic                         raw_mode;

  modport source (output valid, output pen_down, output sample, output raw_mode,
                  input ready);
  modport sink (input valid, input pen_down, input sample, input raw_mode,
                output ready);
endinterface

>>> rtl/tsf_out_if.sv
// Result channel of the touch sample filter: press flags and coordinates per beat.
// Depends on tsf_pkg for the coordinate width.
`timescale 1ns / 1ps

interface tsf_out_if;
  logic                      valid;
  logic                      ready;
  logic                      pressed;
  logic                      caught;
  logic                      reading_valid;
  logic [tsf_pkg::POS_W-1:0] x_position;
  logic [tsf_pkg::POS_W-1:0] y_position;
  logic [tsf_pkg::POS_W-1:0] first_x;
  logic [tsf_pkg::POS_W-1:0] first_y;

  modport source (output valid, output pressed, output caught, output reading_valid,
                  output x_position, output y_position, output first_x,
                  output first_y, input ready);
  modport sink (input valid, input pressed, input caught, input reading_valid,
                input x_position, input y_position, input first_x, input first_y,
                output ready);
endinterface

>>> rtl/tsf_group_filter.sv
// Per-group trimmed mean: insertion sort one sample per beat, then divide by constant.
// Depends on tsf_pkg. Two pipeline stages: kept sum, then mean.
`timescale 1ns / 1ps

module tsf_group_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  tsf_pkg::item_t      s0_i,
  output tsf_pkg::mean_beat_t s2_o
);

  logic [tsf_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic [tsf_pkg::GRP_W-1:0]    grp_q, grp_d;
  logic [tsf_pkg::ADC_BITS-1:0] sorted_q [tsf_pkg::SAMPLES_PER_GROUP];
  logic [tsf_pkg::ADC_BITS-1:0] sorted_d [tsf_pkg::SAMPLES_PER_GROUP];
  logic [tsf_pkg::SUM_W-1:0]    total_q, total_d, drop_sum, kept_sum;
  logic [tsf_pkg::SAMPLES_PER_GROUP-1:0] le;
  logic                         last_slot;
  logic [tsf_pkg::DIV_PROD_W-1:0] prod;

  tsf_pkg::sum_beat_t  s1_q;
  tsf_pkg::mean_beat_t s2_q;

  always_comb begin
    last_slot = (slot_q == tsf_pkg::SLOT_W'(tsf_pkg::SAMPLES_PER_GROUP - 1));
    // The first slot_q entries are sorted, so le is a run of ones from the bottom.
    for (int i = 0; i < tsf_pkg::SAMPLES_PER_GROUP; i++) begin
      le[i] = (tsf_pkg::SLOT_W'(i) < slot_q) && (sorted_q[i] <= s0_i.sample);
    end
    sorted_d[0] = le[0] ? sorted_q[0] : s0_i.sample;
    for (int i = 1; i < tsf_pkg::SAMPLES_PER_GROUP; i++) begin
      if (le[i]) begin
        sorted_d[i] = sorted_q[i];
      end else if (le[i-1]) begin
        sorted_d[i] = s0_i.sample;
      end else begin
        sorted_d[i] = sorted_q[i-1];
      end
    end
    total_d = ((slot_q == '0) ? '0 : total_q) + tsf_pkg::SUM_W'(s0_i.sample);
    drop_sum = '0;
    for (int i = 0; i < tsf_pkg::DROP_EACH_END; i++) begin
      drop_sum = drop_sum + tsf_pkg::SUM_W'(sorted_d[i])
               + tsf_pkg::SUM_W'(sorted_d[tsf_pkg::SAMPLES_PER_GROUP-1-i]);
    end
    kept_sum = total_d - drop_sum;

    slot_d = slot_q;
    grp_d  = grp_q;
    if (s0_i.valid) begin
      if (!s0_i.pen_down) begin
        slot_d = '0;
        grp_d  = '0;
      end else if (last_slot) begin
        slot_d = '0;
        grp_d  = grp_q + 1'b1;
      end else begin
        slot_d = slot_q + 1'b1;
      end
    end
  end

  assign prod = tsf_pkg::DIV_PROD_W'(s1_q.kept_sum) * tsf_pkg::DIV_PROD_W'(tsf_pkg::DIV_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      grp_q  <= '0;
      s1_q   <= '0;
      s2_q   <= '0;
    end else if (advance_i) begin
      slot_q         <= slot_d;
      grp_q          <= grp_d;
      s1_q.valid     <= s0_i.valid;
      s1_q.pen_down  <= s0_i.pen_down;
      s1_q.grp_end   <= s0_i.pen_down && last_slot;
      s1_q.grp       <= grp_q;
      s1_q.raw_mode  <= s0_i.raw_mode;
      s1_q.kept_sum  <= kept_sum;
      s2_q.valid     <= s1_q.valid;
      s2_q.pen_down  <= s1_q.pen_down;
      s2_q.grp_end   <= s1_q.grp_end;
      s2_q.grp       <= s1_q.grp;
      s2_q.raw_mode  <= s1_q.raw_mode;
      s2_q.mean      <= prod[tsf_pkg::DIV_SHIFT +: tsf_pkg::ADC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && s0_i.valid && s0_i.pen_down) begin
      sorted_q <= sorted_d;
      total_q  <= total_d;
    end
  end

  assign s2_o = s2_q;

endmodule

>>> rtl/tsf_pair_calib.sv
// Pair check and calibration: stores the first three group means, checks agreement,
// averages the pair and, outside raw mode, applies gain and offset. Depends on tsf_pkg.
`timescale 1ns / 1ps

module tsf_pair_calib (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  tsf_pkg::cfg_t        cfg_i,
  input  tsf_pkg::mean_beat_t  s2_i,
  output tsf_pkg::calib_beat_t s4_o
);

  logic [tsf_pkg::ADC_BITS-1:0]   means_q [tsf_pkg::MEANS];
  logic [tsf_pkg::ADC_BITS-1:0]   x1, x2, y1, y2, dx, dy;
  logic [tsf_pkg::ADC_BITS:0]     sum_x, sum_y;
  logic                           ok;
  logic [tsf_pkg::CAL_PROD_W-1:0] prod_x, prod_y;
  logic [tsf_pkg::POS_W-1:0]      cal_x, cal_y;

  tsf_pkg::pair_beat_t  s3_q;
  tsf_pkg::calib_beat_t s4_q;

  always_comb begin
    // The Y mean of the second reading is still in the stage register.
    x1 = means_q[0];
    y1 = means_q[1];
    x2 = means_q[2];
    y2 = s2_i.mean;
    dx = (x1 >= x2) ? (x1 - x2) : (x2 - x1);
    dy = (y1 >= y2) ? (y1 - y2) : (y2 - y1);
    ok = (dx < cfg_i.window) && (dy < cfg_i.window);
    sum_x = {1'b0, x1} + {1'b0, x2};
    sum_y = {1'b0, y1} + {1'b0, y2};
  end

  always_comb begin
    prod_x = tsf_pkg::CAL_PROD_W'(cfg_i.x_gain) * tsf_pkg::CAL_PROD_W'(s3_q.ax);
    prod_y = tsf_pkg::CAL_PROD_W'(cfg_i.y_gain) * tsf_pkg::CAL_PROD_W'(s3_q.ay);
    cal_x  = tsf_pkg::POS_W'(prod_x[tsf_pkg::CAL_PROD_W-1:tsf_pkg::GAIN_FRAC]) + cfg_i.x_offset;
    cal_y  = tsf_pkg::POS_W'(prod_y[tsf_pkg::CAL_PROD_W-1:tsf_pkg::GAIN_FRAC]) + cfg_i.y_offset;
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && s2_i.valid && s2_i.grp_end && (s2_i.grp != tsf_pkg::LAST_GRP)) begin
      means_q[s2_i.grp] <= s2_i.mean;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
      s4_q <= '0;
    end else if (advance_i) begin
      s3_q.valid    <= s2_i.valid;
      s3_q.pen_down <= s2_i.pen_down;
      s3_q.scan_end <= s2_i.grp_end && (s2_i.grp == tsf_pkg::LAST_GRP);
      s3_q.raw_mode <= s2_i.raw_mode;
      s3_q.ok       <= ok;
      s3_q.ax       <= sum_x[tsf_pkg::ADC_BITS:1];
      s3_q.ay       <= sum_y[tsf_pkg::ADC_BITS:1];
      s4_q.valid    <= s3_q.valid;
      s4_q.pen_down <= s3_q.pen_down;
      s4_q.scan_end <= s3_q.scan_end;
      s4_q.ok       <= s3_q.ok;
      s4_q.x        <= s3_q.raw_mode ? tsf_pkg::POS_W'(s3_q.ax) : cal_x;
      s4_q.y        <= s3_q.raw_mode ? tsf_pkg::POS_W'(s3_q.ay) : cal_y;
    end
  end

  assign s4_o = s4_q;

endmodule

>>> rtl/touch_sample_filter_and_press_tracker_top.sv
// Touch sample filter and press tracker, top level.
// Throughput: one item per cycle while intake is not stalled. A result passes the input
// register, four stages and the result register before it is in the output register.
// Intake stalls only while a result waits unaccepted and another reaches the last stage.
// Reset (async, active low) clears scan progress, press state, positions and
// loads the calibration registers with their defaults.
`timescale 1ns / 1ps
`include "touch_sample_filter_and_press_tracker_top_assert.svh"

module touch_sample_filter_and_press_tracker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tsf_in_if.sink                        item_i,
  tsf_out_if.source                     result_o,
  input  logic                          cfg_we_i,
  input  logic [tsf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  tsf_pkg::cfg_t        cfg_q;
  tsf_pkg::item_t       s0_q;
  tsf_pkg::mean_beat_t  s2;
  tsf_pkg::calib_beat_t s4;
  tsf_pkg::result_t     out_q;

  logic                      advance, has_result, out_valid_q, reading_valid;
  logic                      press_q, press_d, catch_q, catch_d;
  logic [tsf_pkg::POS_W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [tsf_pkg::POS_W-1:0] start_x_q, start_x_d, start_y_q, start_y_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_gain   <= tsf_pkg::X_GAIN_RST;
      cfg_q.x_offset <= tsf_pkg::X_OFFSET_RST;
      cfg_q.y_gain   <= tsf_pkg::Y_GAIN_RST;
      cfg_q.y_offset <= tsf_pkg::Y_OFFSET_RST;
      cfg_q.window   <= tsf_pkg::WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (tsf_pkg::cfg_reg_e'(cfg_idx_i))
        tsf_pkg::CFG_X_GAIN:       cfg_q.x_gain   <= cfg_wdata_i[tsf_pkg::GAIN_W-1:0];
        tsf_pkg::CFG_X_OFFSET:     cfg_q.x_offset <= cfg_wdata_i[tsf_pkg::OFF_W-1:0];
        tsf_pkg::CFG_Y_GAIN:       cfg_q.y_gain   <= cfg_wdata_i[tsf_pkg::GAIN_W-1:0];
        tsf_pkg::CFG_Y_OFFSET:     cfg_q.y_offset <= cfg_wdata_i[tsf_pkg::OFF_W-1:0];
        tsf_pkg::CFG_AGREE_WINDOW: cfg_q.window   <= cfg_wdata_i[tsf_pkg::WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Beats without a result drain through the last stage even while the
  // output register is held.
  assign has_result = s4.valid && (!s4.pen_down || s4.scan_end);
  assign advance    = !(out_valid_q && !result_o.ready && has_result);
  assign item_i.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (advance) begin
      s0_q.valid    <= item_i.valid;
      s0_q.pen_down <= item_i.pen_down;
      s0_q.sample   <= item_i.sample;
      s0_q.raw_mode <= item_i.raw_mode;
    end
  end

  tsf_group_filter u_group_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .s0_i      (s0_q),
    .s2_o      (s2)
  );

  tsf_pair_calib u_pair_calib (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cfg_i     (cfg_q),
    .s2_i      (s2),
    .s4_o      (s4)
  );

  always_comb begin
    press_d       = press_q;
    catch_d       = catch_q;
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    start_x_d     = start_x_q;
    start_y_d     = start_y_q;
    reading_valid = 1'b0;
    if (s4.valid) begin
      if (!s4.pen_down) begin
        if (press_q) begin
          press_d = 1'b0;
        end else begin
          start_x_d = '0;
          start_y_d = '0;
          cur_x_d   = tsf_pkg::POS_IDLE;
          cur_y_d   = tsf_pkg::POS_IDLE;
        end
      end else if (s4.scan_end) begin
        reading_valid = s4.ok;
        if (s4.ok) begin
          cur_x_d = s4.x;
          cur_y_d = s4.y;
        end
        // A new press records where it began.
        if (!press_q) begin
          press_d   = 1'b1;
          catch_d   = 1'b1;
          start_x_d = cur_x_d;
          start_y_d = cur_y_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q   <= 1'b0;
      catch_q   <= 1'b0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
    end else if (advance) begin
      press_q   <= press_d;
      catch_q   <= catch_d;
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_q.pressed       <= press_d;
      out_q.caught        <= catch_d;
      out_q.reading_valid <= reading_valid;
      out_q.x_position    <= cur_x_d;
      out_q.y_position    <= cur_y_d;
      out_q.first_x       <= start_x_d;
      out_q.first_y       <= start_y_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.pressed       = out_q.pressed;
  assign result_o.caught        = out_q.caught;
  assign result_o.reading_valid = out_q.reading_valid;
  assign result_o.x_position    = out_q.x_position;
  assign result_o.y_position    = out_q.y_position;
  assign result_o.first_x       = out_q.first_x;
  assign result_o.first_y       = out_q.first_y;

  `TSF_ASSERT(a_press_implies_caught, clk_i, rst_ni, press_q |-> catch_q)
  `TSF_ASSERT(a_start_clear_uncaught, clk_i, rst_ni, !catch_q |-> (start_x_q == '0 && start_y_q == '0))
  `TSF_ASSERT(a_valid_reading_pressed, clk_i, rst_ni, (out_valid_q && out_q.reading_valid) |-> out_q.pressed)
  `TSF_ASSERT_NEXT(a_pen_up_result, clk_i, rst_ni, advance && has_result && !s4.pen_down, out_valid_q && !out_q.reading_valid)

endmodule
